// ===== rtl/bb3_pkg.sv =====
// Shared types and constants for the 3x3 box-blur pixel store.
`timescale 1ns / 1ps
`default_nettype none
package bb3_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int DIM_W       = 13;
    localparam int COORD_W     = 12;
    localparam int PIX_W       = 32;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = PIX_W / CHAN_W;
    localparam int IDX_W       = COORD_W + DIM_W + 1;
    localparam int NB_W        = (ADDR_W > DIM_W ? ADDR_W : DIM_W) + 2;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int TAPS        = 9;
    localparam int STEP_W      = 4;

    localparam logic [RECIP_W-1:0]   RECIP_NINE   = 13'd7282;
    localparam logic [DIM_W-1:0]     WIDTH_RESET  = 13'd256;
    localparam logic [DIM_W-1:0]     HEIGHT_RESET = 13'd256;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic                 FUNC_WRITE   = 1'b0;
    localparam logic                 FUNC_READ    = 1'b1;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   write_pixel;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] filtered_pixel;
        logic             position_error;
    } out_t;

    typedef struct packed {
        logic clear;
        logic add;
    } acc_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOCATE,
        ST_DECIDE,
        ST_WALK,
        ST_DRAIN,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/bb3_ram.sv =====
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bb3_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bb3_accum.sv =====
// Per-channel neighbour sums and divide-by-nine of the box filter.
`timescale 1ns / 1ps
`default_nettype none
module bb3_accum (
    input  wire logic                     aclk,
    input  wire bb3_pkg::acc_ctl_t        ctl,
    input  wire logic [bb3_pkg::PIX_W-1:0] word,
    output logic      [bb3_pkg::PIX_W-1:0] average
);

    localparam int PROD_W = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

    logic [bb3_pkg::SUM_W-1:0]  sum_reg  [bb3_pkg::NUM_CHAN];
    logic [bb3_pkg::SUM_W-1:0]  sum_next [bb3_pkg::NUM_CHAN];
    logic [bb3_pkg::CHAN_W-1:0] quot_reg [bb3_pkg::NUM_CHAN];
    logic [PROD_W-1:0]          prod     [bb3_pkg::NUM_CHAN];

    always_comb begin
        for (int c = 0; c < bb3_pkg::NUM_CHAN; c++) begin
            if (ctl.clear) begin
                sum_next[c] = '0;
            end else if (ctl.add) begin
                sum_next[c] = sum_reg[c] + bb3_pkg::SUM_W'(word[c*bb3_pkg::CHAN_W +:
                                                               bb3_pkg::CHAN_W]);
            end else begin
                sum_next[c] = sum_reg[c];
            end
            // floor(x/9) for x below 2304: multiply by ceil(2^16/9), keep the top
            prod[c] = PROD_W'(sum_reg[c]) * PROD_W'(bb3_pkg::RECIP_NINE);
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < bb3_pkg::NUM_CHAN; c++) begin
            sum_reg[c]  <= sum_next[c];
            quot_reg[c] <= prod[c][bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
        end
    end

    always_comb begin
        for (int c = 0; c < bb3_pkg::NUM_CHAN; c++) begin
            average[c*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W] = quot_reg[c];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/box_blur_3x3_pixel_store_unit.sv =====
// Box-blur pixel store: a write stores a word, a read returns the 3x3 mean of its neighbours.
// Write beat: LOCATE registers the index, DECIDE stores the word; no result.
// Read beat: LOCATE, DECIDE, then WALK issues nine one-per-cycle reads of the single-port frame RAM,
// then DRAIN, DIVIDE and EMIT raise m_valid; an out-of-frame read goes from DECIDE straight to EMIT.
// One beat at a time; the result register lets the next beat in while a result waits.
// Synchronous active-low reset clears control, loads 256 x 256; frame RAM undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_3x3_pixel_store_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire bb3_pkg::in_t                    s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output bb3_pkg::out_t                        m_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PROD_W = 2 * bb3_pkg::DIM_W;

    bb3_pkg::state_t state_reg, state_next;

    logic [bb3_pkg::DIM_W-1:0]   width_reg, height_reg;
    bb3_pkg::in_t                item_reg;
    logic [bb3_pkg::IDX_W-1:0]   idx_reg;
    logic [bb3_pkg::SIZE_W-1:0]  size_reg;
    logic [bb3_pkg::ADDR_W-1:0]  last_reg, last_next;
    logic [bb3_pkg::NB_W-1:0]    nb_reg, nb_next;
    logic [bb3_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [1:0]                  dr_reg, dr_next;
    logic                        err_reg, err_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic                        m_valid_reg, m_valid_next;
    bb3_pkg::out_t               m_data_reg, m_data_next;

    logic [bb3_pkg::IDX_W-1:0]   idx_calc;
    logic [PROD_W-1:0]           area;
    logic [bb3_pkg::SIZE_W-1:0]  size_calc;
    logic                        outside;
    logic [bb3_pkg::ADDR_W-1:0]  nb_addr;

    logic                        ram_en, ram_we;
    logic [bb3_pkg::ADDR_W-1:0]  ram_addr;
    logic [bb3_pkg::PIX_W-1:0]   ram_rdata;
    logic [bb3_pkg::PIX_W-1:0]   average;
    bb3_pkg::acc_ctl_t           acc_ctl;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == bb3_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Linear index and frame size, registered in LOCATE
    assign idx_calc  = bb3_pkg::IDX_W'(item_reg.column) * bb3_pkg::IDX_W'(height_reg)
                     + bb3_pkg::IDX_W'(item_reg.row);
    assign area      = PROD_W'(width_reg) * PROD_W'(height_reg);
    assign size_calc = (area > PROD_W'(bb3_pkg::STORE_DEPTH))
                     ? bb3_pkg::SIZE_W'(bb3_pkg::STORE_DEPTH) : bb3_pkg::SIZE_W'(area);

    assign outside = ({1'b0, item_reg.column} >= width_reg)
                  || ({1'b0, item_reg.row} >= height_reg)
                  || (idx_reg >= bb3_pkg::IDX_W'(size_reg));

    // Linear clamp of the neighbour index into the frame
    always_comb begin
        if (nb_reg[bb3_pkg::NB_W-1]) begin
            nb_addr = '0;
        end else if (nb_reg[bb3_pkg::NB_W-2:0] > (bb3_pkg::NB_W-1)'(last_reg)) begin
            nb_addr = last_reg;
        end else begin
            nb_addr = bb3_pkg::ADDR_W'(nb_reg);
        end
    end

    always_comb begin
        state_next    = state_reg;
        last_next     = last_reg;
        nb_next       = nb_reg;
        step_next     = step_reg;
        dr_next       = dr_reg;
        err_next      = err_reg;
        rd_valid_next = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = nb_addr;
        acc_ctl       = '{clear: 1'b0, add: rd_valid_reg};

        unique case (state_reg)
            bb3_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = bb3_pkg::ST_LOCATE;
                end
            end
            bb3_pkg::ST_LOCATE: begin
                state_next = bb3_pkg::ST_DECIDE;
            end
            bb3_pkg::ST_DECIDE: begin
                err_next  = outside;
                last_next = bb3_pkg::ADDR_W'(size_reg - bb3_pkg::SIZE_W'(1));
                nb_next   = bb3_pkg::NB_W'(idx_reg) - bb3_pkg::NB_W'(height_reg)
                          - bb3_pkg::NB_W'(1);
                step_next = '0;
                dr_next   = '0;
                acc_ctl.clear = 1'b1;
                if (item_reg.func == bb3_pkg::FUNC_WRITE) begin
                    ram_en     = !outside;
                    ram_we     = 1'b1;
                    ram_addr   = bb3_pkg::ADDR_W'(idx_reg);
                    state_next = bb3_pkg::ST_IDLE;
                end else if (outside) begin
                    state_next = bb3_pkg::ST_EMIT;
                end else begin
                    state_next = bb3_pkg::ST_WALK;
                end
            end
            bb3_pkg::ST_WALK: begin
                ram_en        = 1'b1;
                rd_valid_next = 1'b1;
                step_next     = step_reg + bb3_pkg::STEP_W'(1);
                // next row inside the column, or jump to the top of the next column
                if (dr_reg == 2'd2) begin
                    dr_next = '0;
                    nb_next = nb_reg + bb3_pkg::NB_W'(height_reg) - bb3_pkg::NB_W'(2);
                end else begin
                    dr_next = dr_reg + 2'd1;
                    nb_next = nb_reg + bb3_pkg::NB_W'(1);
                end
                if (step_reg == bb3_pkg::STEP_W'(bb3_pkg::TAPS - 1)) begin
                    state_next = bb3_pkg::ST_DRAIN;
                end
            end
            bb3_pkg::ST_DRAIN: begin
                state_next = bb3_pkg::ST_DIVIDE;
            end
            bb3_pkg::ST_DIVIDE: begin
                state_next = bb3_pkg::ST_EMIT;
            end
            bb3_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.position_error = err_reg;
                    m_data_next.filtered_pixel = err_reg ? '0 : average;
                    state_next   = bb3_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bb3_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bb3_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            width_reg    <= bb3_pkg::WIDTH_RESET;
            height_reg   <= bb3_pkg::HEIGHT_RESET;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            rd_valid_reg <= rd_valid_next;
            if (cfg_valid) begin
                if (cfg_index == bb3_pkg::REG_WIDTH) begin
                    width_reg <= cfg_data[bb3_pkg::DIM_W-1:0];
                end else if (cfg_index == bb3_pkg::REG_HEIGHT) begin
                    height_reg <= cfg_data[bb3_pkg::DIM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (state_reg == bb3_pkg::ST_LOCATE) begin
            idx_reg  <= idx_calc;
            size_reg <= size_calc;
        end
        last_reg   <= last_next;
        nb_reg     <= nb_next;
        step_reg   <= step_next;
        dr_reg     <= dr_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
    end

    bb3_ram #(
        .DEPTH  (bb3_pkg::STORE_DEPTH),
        .ADDR_W (bb3_pkg::ADDR_W),
        .DATA_W (bb3_pkg::PIX_W)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item_reg.write_pixel),
        .rdata (ram_rdata)
    );

    bb3_accum u_accum (
        .aclk    (aclk),
        .ctl     (acc_ctl),
        .word    (ram_rdata),
        .average (average)
    );

endmodule
`default_nettype wire
